/* src/ordered_double_hash_table_defines.svh */
// Assertion helpers for the hash table sequencer
`ifndef ORDERED_DOUBLE_HASH_TABLE_DEFINES_SVH
`define ORDERED_DOUBLE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define ODHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/odht_pkg.sv */
`default_nettype none

package odht_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned HashW    = 31;
  localparam int unsigned DataW    = 32;
  localparam int unsigned SizeW    = 10;
  localparam int unsigned CountW   = 10;
  localparam int unsigned DefDepth = 512;

  localparam logic [SizeW-1:0] SizeReset = 10'd509;
  localparam logic [SizeW-1:0] SizeMin   = 10'd3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e              opcode;
    logic [KeyW-1:0]  key_value;
    logic [HashW-1:0] hash_value;
    logic [DataW-1:0] entry_data;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [DataW-1:0]  found_data;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
    logic [DataW-1:0] data;
  } slot_t;

endpackage

`default_nettype wire

/* src/odht_mem.sv */
`default_nettype none

module odht_mem #(
  parameter int unsigned TABLE_DEPTH = odht_pkg::DefDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr_i,
  input  wire odht_pkg::slot_t                wdata_i,
  output odht_pkg::slot_t                     rdata_o
);

  odht_pkg::slot_t mem_q [TABLE_DEPTH];
  odht_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/odht_div.sv */
`default_nettype none

// two restoring remainder lanes sharing one dividend, one bit per cycle
module odht_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [odht_pkg::HashW-1:0]   dividend_i,
  input  wire logic [odht_pkg::SizeW-1:0]   divisor_a_i,
  input  wire logic [odht_pkg::SizeW-1:0]   divisor_b_i,
  output logic                              done_o,
  output logic [odht_pkg::SizeW-1:0]        rem_a_o,
  output logic [odht_pkg::SizeW-1:0]        rem_b_o
);

  localparam int unsigned CntW = $clog2(odht_pkg::HashW);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [odht_pkg::HashW-1:0]   dvd_q, dvd_d;
  logic [odht_pkg::SizeW-1:0]   ra_q, ra_d, rb_q, rb_d;

  function automatic logic [odht_pkg::SizeW-1:0] rem_step(
    input logic [odht_pkg::SizeW-1:0] r,
    input logic                       b,
    input logic [odht_pkg::SizeW-1:0] d
  );
    logic [odht_pkg::SizeW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[odht_pkg::SizeW-1:0];
  endfunction

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(odht_pkg::HashW - 1);
      dvd_d  = dividend_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      ra_d  = rem_step(ra_q, dvd_q[odht_pkg::HashW-1], divisor_a_i);
      rb_d  = rem_step(rb_q, dvd_q[odht_pkg::HashW-1], divisor_b_i);
      dvd_d = {dvd_q[odht_pkg::HashW-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
  end

  assign done_o  = done_q;
  assign rem_a_o = ra_q;
  assign rem_b_o = rb_q;

endmodule

`default_nettype wire

/* src/ordered_double_hash_table.sv */
// After reset a clearing pass empties all TABLE_DEPTH slots of the memory; no transfer is
// taken meanwhile. The size register resets to 509 and the entry count to zero.
// Per item: the home and step residues come from a bit-serial remainder unit, then each
// probed slot takes one memory read and one compare, then the result is handed over.
// Each displaced entry gets new residues and probes from its own home. One item at a time;
// the next transfer is taken while the previous result waits in the output register.
`default_nettype none
`include "ordered_double_hash_table_defines.svh"

module ordered_double_hash_table #(
  parameter int unsigned TABLE_DEPTH = odht_pkg::DefDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [odht_pkg::SizeW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire odht_pkg::req_t             in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output odht_pkg::rsp_t                  out_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DcW  = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned SW   = odht_pkg::SizeW;

  odht_pkg::state_e              state_q, state_d;
  logic [SW-1:0]                 cfg_q;
  logic [SW-1:0]                 size;
  logic [AW-1:0]                 clr_q, clr_d;
  odht_pkg::op_e                 op_q, op_d;
  logic [odht_pkg::KeyW-1:0]     key_q, key_d;
  logic [odht_pkg::HashW-1:0]    hash_q, hash_d;
  logic [odht_pkg::DataW-1:0]    data_q, data_d;
  logic [SW-1:0]                 home_q, home_d, step_q, step_d, loc_q, loc_d;
  logic                          disp_q, disp_d;
  logic [DcW-1:0]                dcnt_q, dcnt_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  odht_pkg::status_e             status_q, status_d;
  logic [odht_pkg::DataW-1:0]    found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  odht_pkg::rsp_t                out_q, out_d;

  logic                          mem_en, mem_we;
  logic [AW-1:0]                 mem_addr;
  odht_pkg::slot_t               mem_wdata, rd;
  logic                          div_start, div_done;
  logic [odht_pkg::HashW-1:0]    div_dvd;
  logic [SW-1:0]                 rem_a, rem_b;
  logic [SW:0]                   nsum;
  logic [SW-1:0]                 nloc;
  logic                          full_now;

  always_comb begin
    size = cfg_q;
    if (cfg_q < odht_pkg::SizeMin) begin
      size = odht_pkg::SizeMin;
    end else if (32'(cfg_q) > 32'(TABLE_DEPTH)) begin
      size = SW'(TABLE_DEPTH);
    end
  end

  odht_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_a_i (size),
    .divisor_b_i (size - 1'b1),
    .done_o      (div_done),
    .rem_a_o     (rem_a),
    .rem_b_o     (rem_b)
  );

  odht_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rd)
  );

  assign nsum = {1'b0, loc_q} + {1'b0, step_q};
  assign nloc = (nsum >= {1'b0, size}) ? SW'(nsum - {1'b0, size}) : nsum[SW-1:0];
  assign full_now = disp_q ? (dcnt_q == DcW'(TABLE_DEPTH + 1))
                           : (32'(cnt_q) >= 32'(size));

  assign in_stall_o = (state_q != odht_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    hash_d      = hash_q;
    data_d      = data_q;
    home_d      = home_q;
    step_d      = step_q;
    loc_d       = loc_q;
    disp_d      = disp_q;
    dcnt_d      = dcnt_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = AW'(loc_q);
    mem_wdata   = '{valid: 1'b1, key: key_q, hash: hash_q, data: data_q};
    div_start   = 1'b0;
    div_dvd     = in_i.hash_value;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      odht_pkg::S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = odht_pkg::S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      odht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_i.opcode;
          key_d     = in_i.key_value;
          hash_d    = in_i.hash_value;
          data_d    = in_i.entry_data;
          disp_d    = 1'b0;
          dcnt_d    = '0;
          found_d   = '0;
          div_start = 1'b1;
          state_d   = odht_pkg::S_DIV;
        end
      end
      odht_pkg::S_DIV: begin
        if (div_done) begin
          home_d  = rem_a;
          step_d  = rem_b + 1'b1;
          loc_d   = rem_a;
          state_d = odht_pkg::S_READ;
        end
      end
      odht_pkg::S_READ: begin
        mem_en  = 1'b1;
        state_d = odht_pkg::S_CMP;
      end
      odht_pkg::S_CMP: begin
        priority if (!rd.valid) begin
          state_d = odht_pkg::S_FIN;
          if (op_q == odht_pkg::OP_LOOKUP) begin
            status_d = odht_pkg::ST_NOT_FOUND;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            cnt_d    = cnt_q + 1'b1;
            status_d = odht_pkg::ST_INSERTED;
          end
        end else if (rd.key == key_q) begin
          state_d = odht_pkg::S_FIN;
          if (op_q == odht_pkg::OP_LOOKUP) begin
            status_d = odht_pkg::ST_FOUND;
            found_d  = rd.data;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            status_d = disp_q ? odht_pkg::ST_INSERTED : odht_pkg::ST_REPLACED;
          end
        end else if (rd.key < key_q) begin
          if (op_q == odht_pkg::OP_LOOKUP) begin
            status_d = odht_pkg::ST_NOT_FOUND;
            state_d  = odht_pkg::S_FIN;
          end else if (full_now) begin
            status_d = odht_pkg::ST_FULL;
            state_d  = odht_pkg::S_FIN;
          end else begin
            // swap in the carried entry, carry the smaller one on from its own home
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            key_d     = rd.key;
            hash_d    = rd.hash;
            data_d    = rd.data;
            disp_d    = 1'b1;
            dcnt_d    = dcnt_q + 1'b1;
            div_start = 1'b1;
            div_dvd   = rd.hash;
            state_d   = odht_pkg::S_DIV;
          end
        end else if (nloc == home_q) begin
          status_d = (op_q == odht_pkg::OP_LOOKUP) ? odht_pkg::ST_NOT_FOUND
                                                   : odht_pkg::ST_FULL;
          state_d  = odht_pkg::S_FIN;
        end else begin
          loc_d   = nloc;
          state_d = odht_pkg::S_READ;
        end
      end
      odht_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = '{status: status_q, found_data: found_q,
                          entry_count: odht_pkg::CountW'(cnt_q)};
          state_d     = odht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = odht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= odht_pkg::S_CLEAR;
      cfg_q       <= odht_pkg::SizeReset;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    hash_q   <= hash_d;
    data_q   <= data_d;
    home_q   <= home_d;
    step_q   <= step_d;
    loc_q    <= loc_d;
    disp_q   <= disp_d;
    dcnt_q   <= dcnt_d;
    status_q <= status_d;
    found_q  <= found_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ODHT_ASSERT_NXT(a_accept_div, in_valid_i && !in_stall_o, state_q == odht_pkg::S_DIV, "transfer not followed by residue phase")
  `ODHT_ASSERT_NXT(a_div_read, state_q == odht_pkg::S_DIV && div_done, state_q == odht_pkg::S_READ, "residues ready but no slot read")
  `ODHT_ASSERT_IMP(a_loc_range, state_q == odht_pkg::S_READ, loc_q < size, "probe slot outside table size")
  `ODHT_ASSERT_IMP(a_lookup_ro, mem_we && state_q == odht_pkg::S_CMP, op_q == odht_pkg::OP_INSERT, "lookup wrote the table")
  `ODHT_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt_q) <= 32'(TABLE_DEPTH), "entry count above table depth")

endmodule

`default_nettype wire
